// ===== rtl/core/lef_pkg.sv =====
// Package for the lattice electric field core: item structs, status and operation codes.
// Depends on nothing; the front, the back, the top level and the bench import it.
`default_nettype none

package lef_pkg;

   localparam int DATA_W      = 32;
   localparam int GRID_W      = 5;
   localparam int SITE_W      = 4;
   // A wrapped neighbour coordinate can reach sixteen, so coordinates carry one more bit.
   localparam int COORD_W     = SITE_W + 1;
   localparam int AXES        = 3;
   localparam int FRAC_W      = 16;
   localparam int MID_DEPTH   = 4;
   localparam int OUT_DEPTH   = 8;
   localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_SIZE      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_TIME_SCALE = 1'b1;

   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_COMPUTE = 1'b1;

   localparam logic [GRID_W-1:0] GRID_RESET = 5'd16;
   localparam logic [DATA_W-1:0] INV_RESET  = 32'h0001_0000;

   typedef enum logic [2:0] {
      STATUS_LOADED     = 3'd0,
      STATUS_FIELD_OK   = 3'd1,
      STATUS_SATURATED  = 3'd2,
      STATUS_BAD_CONFIG = 3'd3,
      STATUS_BAD_SITE   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_COMPUTE = 2'd1,
      OP_REPORT  = 2'd2
   } op_type;

   typedef struct packed {
      logic                     req_type;
      logic [SITE_W-1:0]        site_x;
      logic [SITE_W-1:0]        site_y;
      logic [SITE_W-1:0]        site_z;
      logic signed [DATA_W-1:0] phi_value;
      logic signed [DATA_W-1:0] a_start_x;
      logic signed [DATA_W-1:0] a_start_y;
      logic signed [DATA_W-1:0] a_start_z;
      logic signed [DATA_W-1:0] a_end_x;
      logic signed [DATA_W-1:0] a_end_y;
      logic signed [DATA_W-1:0] a_end_z;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] field_x;
      logic signed [DATA_W-1:0] field_y;
      logic signed [DATA_W-1:0] field_z;
      status_type               status;
   } rsp_item_type;

   typedef struct packed {
      logic [GRID_W-1:0] grid_size;
      logic [DATA_W-1:0] inv_time_scale;
   } cfg_type;

   // Classified item as it waits between the front and the back.
   typedef struct packed {
      op_type                             op;
      status_type                         status;
      logic [AXES-1:0][COORD_W-1:0]       here;
      logic [AXES-1:0][COORD_W-1:0]       next;
      logic [DATA_W-1:0]                  phi;
      logic [AXES-1:0][DATA_W-1:0]        mag;
      logic [AXES-1:0]                    neg;
   } work_type;

endpackage

`default_nettype wire

// ===== rtl/core/lef_queue.sv =====
// Small first-in first-out queue of registered slots, generic in its entry type.
// Depends on nothing; used between front and back and on the result side.
`default_nettype none

module lef_queue #(
   parameter type entry_type = logic,
   parameter int  DEPTH      = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire entry_type                  push_data,
   output logic                            full,
   input  wire logic                       pop,
   output entry_type                       pop_data,
   output logic                            empty,
   output logic [$clog2(DEPTH + 1)-1:0]    count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   entry_type         slots_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in  = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = slots_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== rtl/core/lef_front.sv =====
// Front end of the lattice electric field core: takes items and classifies them.
// Depends on lef_pkg; feeds the work queue that the back end drains.
`default_nettype none

module lef_front import lef_pkg::*; #(
   parameter int GRID_MAX = 16
) (
   input  wire logic         req_push,
   input  wire req_item_type req_data,
   output logic             req_full,
   input  wire cfg_type      cfg,
   input  wire logic         clearing,
   input  wire logic         mid_full,
   output logic             mid_push,
   output work_type         mid_data
);

   logic [GRID_W-1:0]             eff_grid;
   logic [AXES-1:0][COORD_W-1:0]  site;
   logic [AXES-1:0][DATA_W-1:0]   a_start;
   logic [AXES-1:0][DATA_W-1:0]   a_end;
   logic [COORD_W-1:0]            step;
   logic [DATA_W:0]               diff;
   logic                          bad_site;

   always_comb begin
      // Grid size zero acts as one; beyond the store it acts as the store edge.
      if (cfg.grid_size == '0) begin
         eff_grid = GRID_W'(1);
      end else if (int'(cfg.grid_size) > GRID_MAX) begin
         eff_grid = GRID_W'(GRID_MAX);
      end else begin
         eff_grid = cfg.grid_size;
      end

      site[0]    = COORD_W'(req_data.site_x);
      site[1]    = COORD_W'(req_data.site_y);
      site[2]    = COORD_W'(req_data.site_z);
      a_start[0] = req_data.a_start_x;
      a_start[1] = req_data.a_start_y;
      a_start[2] = req_data.a_start_z;
      a_end[0]   = req_data.a_end_x;
      a_end[1]   = req_data.a_end_y;
      a_end[2]   = req_data.a_end_z;

      bad_site = 1'b0;
      mid_data = '0;
      for (int a = 0; a < AXES; a++) begin
         bad_site         = bad_site || (site[a] >= COORD_W'(eff_grid));
         step             = site[a] + 1'b1;
         mid_data.here[a] = site[a];
         mid_data.next[a] = (step == COORD_W'(eff_grid)) ? '0 : step;
         // The difference of two 32-bit values has a magnitude that fits 32 bits.
         diff             = {a_end[a][DATA_W-1], a_end[a]} - {a_start[a][DATA_W-1], a_start[a]};
         mid_data.neg[a]  = diff[DATA_W];
         mid_data.mag[a]  = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
      end
      mid_data.phi = req_data.phi_value;

      if (bad_site) begin
         mid_data.op     = OP_REPORT;
         mid_data.status = STATUS_BAD_SITE;
      end else begin
         unique case (req_data.req_type)
            REQ_LOAD: begin
               mid_data.op     = OP_LOAD;
               mid_data.status = STATUS_LOADED;
            end
            REQ_COMPUTE: begin
               if (cfg.inv_time_scale == '0) begin
                  mid_data.op     = OP_REPORT;
                  mid_data.status = STATUS_BAD_CONFIG;
               end else begin
                  mid_data.op     = OP_COMPUTE;
                  mid_data.status = STATUS_FIELD_OK;
               end
            end
            default: begin
               mid_data.op     = OP_REPORT;
               mid_data.status = STATUS_BAD_SITE;
            end
         endcase
      end

      req_full = mid_full || clearing;
      mid_push = req_push && !req_full;
   end

endmodule

`default_nettype wire

// ===== rtl/core/lef_back.sv =====
// Back end of the lattice electric field core: potential store and field pipeline.
// Depends on lef_pkg; drains the work queue and pushes into the result queue.
`default_nettype none

module lef_back import lef_pkg::*; #(
   parameter int GRID_MAX = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire logic                  mid_empty,
   input  wire work_type              mid_data,
   output logic                       mid_pop,
   input  wire logic [OUT_CNT_W-1:0]  out_count,
   output logic                       out_push,
   output rsp_item_type               out_data,
   output logic                       clearing
);

   localparam int DEPTH    = GRID_MAX * GRID_MAX * GRID_MAX;
   localparam int AW       = $clog2(DEPTH);
   localparam int COPIES   = AXES + 1;
   localparam int PROD_W   = 2 * DATA_W;
   localparam int SCALED_W = PROD_W - FRAC_W + 1;
   localparam int PDIFF_W  = DATA_W + 1;
   localparam int FIELD_W  = SCALED_W + 2;
   localparam int CREDIT_W = OUT_CNT_W + 1;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);
   localparam logic signed [FIELD_W-1:0] FIELD_MAX =
      FIELD_W'($signed({1'b0, {(DATA_W - 1){1'b1}}}));
   localparam logic signed [FIELD_W-1:0] FIELD_MIN =
      FIELD_W'($signed({1'b1, {(DATA_W - 1){1'b0}}}));

   function automatic logic [AW-1:0] site_addr(input logic [COORD_W-1:0] cx,
                                                input logic [COORD_W-1:0] cy,
                                                input logic [COORD_W-1:0] cz);
      return AW'((int'(cx) * GRID_MAX + int'(cy)) * GRID_MAX + int'(cz));
   endfunction

   // Four copies of the store: one for the site and one for each neighbour.
   logic [DATA_W-1:0]  store_mem [COPIES][DEPTH];
   logic [DATA_W-1:0]  rd_ff [COPIES];
   logic [AW-1:0]      rd_addr [COPIES];
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [DATA_W-1:0]  wr_data;

   logic               clearing_ff, clearing_in;
   logic [AW-1:0]      clear_addr_ff, clear_addr_in;
   logic               issue, credit_ok;
   logic [CREDIT_W-1:0] credit_used;

   logic                            s1_valid_ff, s1_valid_in;
   op_type                          s1_op_ff;
   status_type                      s1_status_ff;
   logic [AXES-1:0][DATA_W-1:0]     s1_mag_ff;
   logic [AXES-1:0]                 s1_neg_ff;

   logic                            s2_valid_ff;
   op_type                          s2_op_ff;
   status_type                      s2_status_ff;
   logic [AXES-1:0]                 s2_neg_ff;
   logic [PROD_W-1:0]               s2_prod_ff [AXES];
   logic [PROD_W-1:0]               s2_prod_in [AXES];
   logic signed [PDIFF_W-1:0]       s2_pdiff_ff [AXES];
   logic signed [PDIFF_W-1:0]       s2_pdiff_in [AXES];

   logic                            s3_valid_ff;
   op_type                          s3_op_ff;
   status_type                      s3_status_ff;
   logic signed [SCALED_W-1:0]      s3_scaled_ff [AXES];
   logic signed [SCALED_W-1:0]      s3_scaled_in [AXES];
   logic signed [PDIFF_W-1:0]       s3_pdiff_ff [AXES];

   logic [PROD_W-1:0]               rounded;
   logic [SCALED_W-2:0]             rounded_mag;
   logic signed [FIELD_W-1:0]       field_full;
   logic [AXES-1:0][DATA_W-1:0]     field;
   logic                            saturated;

   // Clearing pass after reset, one entry of every copy per cycle.
   always_comb begin
      clear_addr_in = clear_addr_ff + 1'b1;
      clearing_in   = clearing_ff && (clear_addr_ff != AW'(DEPTH - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clearing_ff) begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   assign clearing = clearing_ff;

   // An item leaves the work queue only when the result queue has a slot for it.
   always_comb begin
      credit_used = CREDIT_W'(out_count) + CREDIT_W'(s1_valid_ff) + CREDIT_W'(s2_valid_ff)
                    + CREDIT_W'(s3_valid_ff);
      credit_ok   = credit_used < CREDIT_W'(OUT_DEPTH);
      issue       = !clearing_ff && !mid_empty && credit_ok;
      mid_pop     = issue;
      s1_valid_in = issue;

      rd_addr[0] = site_addr(mid_data.here[0], mid_data.here[1], mid_data.here[2]);
      rd_addr[1] = site_addr(mid_data.next[0], mid_data.here[1], mid_data.here[2]);
      rd_addr[2] = site_addr(mid_data.here[0], mid_data.next[1], mid_data.here[2]);
      rd_addr[3] = site_addr(mid_data.here[0], mid_data.here[1], mid_data.next[2]);

      wr_en   = clearing_ff || (issue && (mid_data.op == OP_LOAD));
      wr_addr = clearing_ff ? clear_addr_ff : rd_addr[0];
      wr_data = clearing_ff ? '0 : mid_data.phi;
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < COPIES; c++) begin
         if (wr_en) begin
            store_mem[c][wr_addr] <= wr_data;
         end
         rd_ff[c] <= store_mem[c][rd_addr[c]];
      end
   end

   // Stage one holds the item while the store is read; products start here.
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         s2_prod_in[a]  = PROD_W'(s1_mag_ff[a]) * PROD_W'(cfg.inv_time_scale);
         s2_pdiff_in[a] = PDIFF_W'($signed(rd_ff[a + 1])) - PDIFF_W'($signed(rd_ff[0]));
      end
   end

   // Stage two rounds the product half away from zero and restores its sign.
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         rounded         = s2_prod_ff[a] + ROUND_HALF;
         rounded_mag     = rounded[PROD_W-1:FRAC_W];
         s3_scaled_in[a] = s2_neg_ff[a] ? -$signed({1'b0, rounded_mag})
                                        : $signed({1'b0, rounded_mag});
      end
   end

   // Stage three subtracts the potential step and saturates.
   always_comb begin
      saturated = 1'b0;
      for (int a = 0; a < AXES; a++) begin
         field_full = -FIELD_W'(s3_scaled_ff[a]) - FIELD_W'(s3_pdiff_ff[a]);
         if (field_full > FIELD_MAX) begin
            field[a]  = FIELD_MAX[DATA_W-1:0];
            saturated = 1'b1;
         end else if (field_full < FIELD_MIN) begin
            field[a]  = FIELD_MIN[DATA_W-1:0];
            saturated = 1'b1;
         end else begin
            field[a] = field_full[DATA_W-1:0];
         end
      end

      out_push = s3_valid_ff;
      unique case (s3_op_ff) inside
         OP_COMPUTE: begin
            out_data.field_x = field[0];
            out_data.field_y = field[1];
            out_data.field_z = field[2];
            out_data.status  = saturated ? STATUS_SATURATED : STATUS_FIELD_OK;
         end
         OP_LOAD, OP_REPORT: begin
            out_data.field_x = '0;
            out_data.field_y = '0;
            out_data.field_z = '0;
            out_data.status  = s3_status_ff;
         end
         default: begin
            out_data.field_x = '0;
            out_data.field_y = '0;
            out_data.field_z = '0;
            out_data.status  = s3_status_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff     <= mid_data.op;
      s1_status_ff <= mid_data.status;
      s1_mag_ff    <= mid_data.mag;
      s1_neg_ff    <= mid_data.neg;

      s2_op_ff     <= s1_op_ff;
      s2_status_ff <= s1_status_ff;
      s2_neg_ff    <= s1_neg_ff;
      s2_prod_ff   <= s2_prod_in;
      s2_pdiff_ff  <= s2_pdiff_in;

      s3_op_ff     <= s2_op_ff;
      s3_status_ff <= s2_status_ff;
      s3_scaled_ff <= s3_scaled_in;
      s3_pdiff_ff  <= s2_pdiff_ff;
   end

`ifndef ASSERT_OFF
   a_issue_has_item: assert property (@(posedge clock) disable iff (reset)
      issue |-> !mid_empty)
      else $error("item issued from an empty work queue");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_used <= CREDIT_W'(OUT_DEPTH))
      else $error("items in flight exceed the result queue space");

   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      clearing_ff && (clear_addr_ff == AW'(DEPTH - 1)) |=> !clearing_ff)
      else $error("clearing pass did not end at the last entry");

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !(s1_valid_ff || s2_valid_ff || s3_valid_ff))
      else $error("item in the pipeline during the clearing pass");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/lattice_electric_field_core.sv =====
// Top level of the lattice electric field core: configuration registers and queues.
// Depends on lef_pkg, lef_front, lef_queue and lef_back.
//
//   Channel     Ports                             Direction  Moves
//   request     req_push, req_full, req_data      in         one load or compute item
//   response    rsp_pop, rsp_empty, rsp_data      out        one result item per request
//   control     csr_we, csr_index, csr_wdata      in         one register write
//
// The core takes one item per clock cycle while req_full is low: the potential store is
// held in four copies, so the site and its three forward neighbours are read together.
// Each taken item passes through the work queue, the field pipeline and the result queue.
// Reset is synchronous; after it the core clears the store, one entry per cycle, through
// all GRID_MAX cubed entries (4096 at the default), and req_full stays high meanwhile.
// A short work queue parts the front from the back, and the back issues an item only when
// the result queue has room for it, so a stalled consumer fills the queues and raises
// req_full without losing an item. Register writes are taken at any time.
`default_nettype none

module lattice_electric_field_core import lef_pkg::*; #(
   parameter int GRID_MAX = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_push,
   output logic                         req_full,
   input  wire req_item_type            req_data,
   output logic                         rsp_empty,
   input  wire logic                    rsp_pop,
   output rsp_item_type                 rsp_data,
   input  wire logic                    csr_we,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [DATA_W-1:0]       csr_wdata
);

   localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

   cfg_type               cfg_ff, cfg_in;
   logic                  clearing;
   logic                  mid_push, mid_full, mid_pop, mid_empty;
   logic [MID_CNT_W-1:0]  mid_count;
   work_type              mid_push_data, mid_pop_data;
   logic                  out_push, out_full;
   rsp_item_type          out_push_data;
   logic [OUT_CNT_W-1:0]  out_count;

   // Configuration registers; the user must keep the block idle when these are written; unchecked.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_SIZE: begin
               cfg_in.grid_size = csr_wdata[GRID_W-1:0];
            end
            CSR_INV_TIME_SCALE: begin
               cfg_in.inv_time_scale = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_size      <= GRID_RESET;
         cfg_ff.inv_time_scale <= INV_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front checks the site and the configuration and works out the neighbours.
   lef_front #(
      .GRID_MAX (GRID_MAX)
   ) u_front (
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cfg      (cfg_ff),
      .clearing (clearing),
      .mid_full (mid_full),
      .mid_push (mid_push),
      .mid_data (mid_push_data)
   );

   lef_queue #(
      .entry_type (work_type),
      .DEPTH      (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_push_data),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_pop_data),
      .empty     (mid_empty),
      .count     (mid_count)
   );

   // The back owns the store and the three-stage field pipeline.
   lef_back #(
      .GRID_MAX (GRID_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .mid_empty (mid_empty),
      .mid_data  (mid_pop_data),
      .mid_pop   (mid_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_data  (out_push_data),
      .clearing  (clearing)
   );

   // Result queue; the back never pushes into it without a free slot.
   lef_queue #(
      .entry_type (rsp_item_type),
      .DEPTH      (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_push_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty),
      .count     (out_count)
   );

`ifndef ASSERT_OFF
   a_out_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result pushed into a full result queue");

   a_mid_bound: assert property (@(posedge clock) disable iff (reset)
      mid_count <= MID_CNT_W'(MID_DEPTH))
      else $error("work queue holds more items than its depth");

   a_full_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_full)
      else $error("input open during the clearing pass");
`endif

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for lattice_electric_field_core: load and compute items, field checks.
// Depends on lef_pkg and the core; it predicts every result from its own copy of the lattice.

module testbench import lef_pkg::*; ();

   // The bench is built for the core's default lattice edge.
   localparam int          LATTICE_MAX = 16;
   localparam int          SITE_COUNT  = LATTICE_MAX * LATTICE_MAX * LATTICE_MAX;
   // The store clear after reset alone covers SITE_COUNT entries with nothing moving.
   localparam int          QUIET_LIMIT = 20000;
   localparam int          LONG_HOLD   = 300;
   localparam int          TAIL_CYCLES = 8;
   localparam int          REPORT_CAP  = 200;
   localparam longint      FIELD_MAX   = 64'sh0000_0000_7FFF_FFFF;
   localparam longint      FIELD_MIN   = -FIELD_MAX - 1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   req_item_type           req_data = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   rsp_item_type           rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_GRID_SIZE;
   logic [DATA_W-1:0]      csr_wdata = '0;

   // Items waiting to be offered, and the results that accepted items must produce, oldest
   // first. The core answers every item with exactly one result.
   req_item_type           site_items[$];
   rsp_item_type           expected_fields[$];

   // The bench's own copy of the lattice potential and of the two registers.
   logic signed [DATA_W-1:0] potential [SITE_COUNT] = '{default: '0};
   logic [GRID_W-1:0]      grid_setting = GRID_RESET;
   logic [DATA_W-1:0]      inv_setting  = INV_RESET;

   // While set, neither side idles outside a receiver hold, so the core sees back-to-back traffic.
   bit                     burst_mode = 1'b0;
   int                     mismatches = 0;
   int                     results_seen = 0;
   int unsigned            push_gap = 0;
   int unsigned            pop_gap = 0;
   int unsigned            hold_left = 0;
   int unsigned            quiet_cycles = 0;
   logic                   push_next;
   logic                   pop_next;
   rsp_item_type           oldest_field;

   lattice_electric_field_core #(
      .GRID_MAX (LATTICE_MAX)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // A grid size of zero behaves as a single site, and anything past the lattice edge is
   // held at the edge.
   function automatic int unsigned lattice_span(logic [GRID_W-1:0] grid);
      if (grid == 0) return 1;
      if (grid > LATTICE_MAX) return LATTICE_MAX;
      return grid;
   endfunction

   function automatic int unsigned store_index(int unsigned x, int unsigned y, int unsigned z);
      return (x * LATTICE_MAX + y) * LATTICE_MAX + z;
   endfunction

   // Works out the result of one accepted item and, for a load, updates the lattice copy.
   // The field on each axis is minus the rate of change of the vector potential, scaled by the
   // reciprocal time scale and rounded half away from zero, less the forward difference of
   // the potential to the wrapped neighbour; each component then clips to 32 bits.
   function automatic rsp_item_type predict_field(req_item_type it);
      rsp_item_type             want;
      int unsigned              span;
      int unsigned              site [3];
      int unsigned              nb [3];
      logic signed [DATA_W-1:0] a0 [3];
      logic signed [DATA_W-1:0] a1 [3];
      longint                   here, there, diff, scaled, e;
      logic [63:0]              mag, prod;
      bit                       clipped;
      int                       ax;
      want = '0;
      span = lattice_span(grid_setting);
      site[0] = it.site_x;
      site[1] = it.site_y;
      site[2] = it.site_z;
      a0[0] = it.a_start_x;
      a0[1] = it.a_start_y;
      a0[2] = it.a_start_z;
      a1[0] = it.a_end_x;
      a1[1] = it.a_end_y;
      a1[2] = it.a_end_z;
      // The site check comes first, for loads and computes alike.
      if (site[0] >= span || site[1] >= span || site[2] >= span) begin
         want.status = STATUS_BAD_SITE;
         return want;
      end
      if (it.req_type == REQ_LOAD) begin
         potential[store_index(site[0], site[1], site[2])] = it.phi_value;
         want.status = STATUS_LOADED;
         return want;
      end
      if (inv_setting == 0) begin
         want.status = STATUS_BAD_CONFIG;
         return want;
      end
      clipped = 1'b0;
      here = potential[store_index(site[0], site[1], site[2])];
      for (ax = 0; ax < 3; ax++) begin
         nb = site;
         nb[ax] = (site[ax] + 1 == span) ? 0 : site[ax] + 1;
         there = potential[store_index(nb[0], nb[1], nb[2])];
         diff = longint'(a1[ax]) - longint'(a0[ax]);
         mag = (diff < 0) ? 64'(-diff) : 64'(diff);
         prod = mag * 64'(inv_setting);
         scaled = longint'((prod + 64'h8000) >> FRAC_W);
         if (diff < 0) scaled = -scaled;
         e = -scaled - (there - here);
         if (e > FIELD_MAX) begin
            e = FIELD_MAX;
            clipped = 1'b1;
         end else if (e < FIELD_MIN) begin
            e = FIELD_MIN;
            clipped = 1'b1;
         end
         case (ax)
            0: begin
               want.field_x = e[31:0];
            end
            1: begin
               want.field_y = e[31:0];
            end
            default: begin
               want.field_z = e[31:0];
            end
         endcase
      end
      want.status = clipped ? STATUS_SATURATED : STATUS_FIELD_OK;
      return want;
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Coordinates cluster at the corners of the lattice so that loads and computes keep
   // meeting the same sites and their wrapped neighbours. A few run over the whole 4-bit
   // range and so fall outside a small lattice.
   function automatic logic [SITE_W-1:0] pick_coord(int unsigned span);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return SITE_W'($urandom_range(0, 15));
      if (r < 35) return SITE_W'($urandom_range(0, span - 1));
      case ($urandom_range(0, 3))
         0: begin
            return '0;
         end
         1: begin
            return SITE_W'(span > 1 ? 1 : 0);
         end
         2: begin
            return SITE_W'(span - 1);
         end
         default: begin
            return SITE_W'(span > 1 ? span - 2 : 0);
         end
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: begin
            return 32'h7FFF_FFFF;
         end
         1: begin
            return 32'h8000_0000;
         end
         2: begin
            return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
         end
         3: begin
            return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // Half the time the end of the slab sits close to its start, so that the field does not
   // always clip.
   function automatic logic [DATA_W-1:0] pick_end(logic [DATA_W-1:0] start);
      if ($urandom_range(0, 1)) return pick_word();
      return start + $urandom_range(0, 1023) - 512;
   endfunction

   function automatic req_item_type random_item();
      req_item_type it;
      int unsigned  span;
      span = lattice_span(grid_setting);
      it = '0;
      it.req_type  = $urandom_range(0, 1) ? REQ_COMPUTE : REQ_LOAD;
      it.site_x    = pick_coord(span);
      it.site_y    = pick_coord(span);
      it.site_z    = pick_coord(span);
      it.phi_value = pick_word();
      it.a_start_x = pick_word();
      it.a_start_y = pick_word();
      it.a_start_z = pick_word();
      it.a_end_x   = pick_end(it.a_start_x);
      it.a_end_y   = pick_end(it.a_start_y);
      it.a_end_z   = pick_end(it.a_start_z);
      return it;
   endfunction

   // Directed items use the same vector potential on all three axes.
   function automatic req_item_type site_item(logic kind, int unsigned x, int unsigned y,
                                              int unsigned z, logic [DATA_W-1:0] phi,
                                              logic [DATA_W-1:0] a_from,
                                              logic [DATA_W-1:0] a_to);
      req_item_type it;
      it.req_type  = kind;
      it.site_x    = SITE_W'(x);
      it.site_y    = SITE_W'(y);
      it.site_z    = SITE_W'(z);
      it.phi_value = phi;
      it.a_start_x = a_from;
      it.a_start_y = a_from;
      it.a_start_z = a_from;
      it.a_end_x   = a_to;
      it.a_end_y   = a_to;
      it.a_end_z   = a_to;
      return it;
   endfunction

   task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                  logic [DATA_W-1:0] want);
      mismatches++;
      if (mismatches <= REPORT_CAP)
         $display("result %0d: %s is %h, expected %h", results_seen, what, got, want);
   endtask

   // Appends one item to the end of the pending list.
   task automatic queue_item(req_item_type it);
      site_items.insert(site_items.size(), it);
   endtask

   task automatic add_random(int count);
      repeat (count) queue_item(random_item());
   endtask

   // The core is idle once nothing waits to be offered and every result has been taken.
   task automatic wait_idle();
      while (site_items.size() != 0 || req_push || expected_fields.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == CSR_GRID_SIZE) grid_setting = value[GRID_W-1:0];
      else inv_setting = value;
   endtask

   // Registers change only between phases, with the core drained.
   task automatic configure(logic [GRID_W-1:0] grid, logic [DATA_W-1:0] inv, bit burst);
      wait_idle();
      write_csr(CSR_GRID_SIZE, DATA_W'(grid));
      write_csr(CSR_INV_TIME_SCALE, inv);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      burst_mode = burst;
   endtask

   // Sender: holds each item until the core takes it, then idles for a random gap unless
   // in burst mode. The expected result is worked out at the edge where the item is taken,
   // so it always sees the lattice as the core does.
   always @(posedge clock) begin
      if (reset) begin
         push_next = 1'b0;
      end else begin
         push_next = req_push;
         if (req_push && !req_full) begin
            expected_fields.insert(expected_fields.size(), predict_field(req_data));
            void'(site_items.pop_front());
            push_gap = burst_mode ? 0 : idle_gap();
            push_next = 1'b0;
         end
         if (!push_next) begin
            if (push_gap > 0) begin
               push_gap--;
            end else if (site_items.size() != 0) begin
               req_data <= site_items[0];
               push_next = 1'b1;
            end
         end
      end
      req_push <= push_next;
   end

   // Receiver: checks each result against the oldest expectation. Twice in the run it stops
   // taking results for a long stretch while the sender keeps offering, so the queues inside
   // the core fill and req_full must rise without an item being lost.
   always @(posedge clock) begin
      if (reset) begin
         pop_next = 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (expected_fields.size() == 0) begin
               report_mismatch("unexpected result, status", DATA_W'(rsp_data.status), '0);
            end else begin
               oldest_field = expected_fields.pop_front();
               if (rsp_data.field_x !== oldest_field.field_x)
                  report_mismatch("field_x", rsp_data.field_x, oldest_field.field_x);
               if (rsp_data.field_y !== oldest_field.field_y)
                  report_mismatch("field_y", rsp_data.field_y, oldest_field.field_y);
               if (rsp_data.field_z !== oldest_field.field_z)
                  report_mismatch("field_z", rsp_data.field_z, oldest_field.field_z);
               if (rsp_data.status !== oldest_field.status)
                  report_mismatch("status", DATA_W'(rsp_data.status),
                                  DATA_W'(oldest_field.status));
            end
            if (results_seen == 60 || results_seen == 320) hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop_next = 1'b0;
         end else if (burst_mode) begin
            pop_next = 1'b1;
         end else if (pop_gap > 0) begin
            pop_gap--;
            pop_next = 1'b0;
         end else begin
            pop_next = 1'b1;
            pop_gap = idle_gap();
         end
      end
      rsp_pop <= pop_next;
   end

   // Watchdog: a run in which neither side moves for too long has hung.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: an edge of sixteen and a time scale of one. Potentials at the
      // extremes next to the origin make the field clip high on two axes, and the
      // far corner checks that every neighbour wraps to zero.
      queue_item(site_item(REQ_LOAD, 0, 0, 0, 32'h7FFF_FFFF, 0, 0));
      queue_item(site_item(REQ_LOAD, 1, 0, 0, 32'h8000_0000, 0, 0));
      queue_item(site_item(REQ_LOAD, 0, 1, 0, 32'hFFFF_FFFF, 0, 0));
      queue_item(site_item(REQ_LOAD, 0, 0, 1, 32'h0001_0000, 0, 0));
      queue_item(site_item(REQ_COMPUTE, 0, 0, 0, 0, 0, 0));
      queue_item(site_item(REQ_LOAD, 15, 15, 15, 32'h0003_0000, 0, 0));
      queue_item(site_item(REQ_LOAD, 0, 15, 15, 32'hFFFF_0000, 0, 0));
      queue_item(site_item(REQ_COMPUTE, 15, 15, 15, 0, 32'h0001_0000,
                           32'h0001_8000));
      // The widest changes of vector potential, in both directions.
      queue_item(site_item(REQ_COMPUTE, 3, 3, 3, 0, 32'h8000_0000,
                           32'h7FFF_FFFF));
      queue_item(site_item(REQ_COMPUTE, 3, 3, 3, 0, 32'h7FFF_FFFF,
                           32'h8000_0000));
      queue_item(site_item(REQ_COMPUTE, 2, 2, 2, 0, 5, 5));
      add_random(110);

      // A time scale of one half puts the scaled change exactly on a half, which must
      // round away from zero on both signs.
      configure(5'd16, 32'h0000_8000, 1'b0);
      queue_item(site_item(REQ_COMPUTE, 8, 8, 8, 0, 0, 32'h0000_0001));
      queue_item(site_item(REQ_COMPUTE, 8, 8, 8, 0, 0, 32'hFFFF_FFFF));
      queue_item(site_item(REQ_COMPUTE, 8, 8, 8, 0, 0, 32'h0000_0003));
      queue_item(site_item(REQ_COMPUTE, 8, 8, 8, 0, 0, 32'hFFFF_FFFD));
      add_random(40);

      // A grid size of zero acts as a single site, which is its own neighbour on every
      // axis; the largest time scale goes with it.
      configure(5'd0, 32'hFFFF_FFFF, 1'b1);
      queue_item(site_item(REQ_LOAD, 0, 0, 0, 32'h0000_0100, 0, 0));
      queue_item(site_item(REQ_COMPUTE, 0, 0, 0, 0, 0, 32'h0000_0001));
      queue_item(site_item(REQ_COMPUTE, 1, 0, 0, 0, 0, 0));
      queue_item(site_item(REQ_LOAD, 0, 0, 2, 32'h1234_5678, 0, 0));
      add_random(40);

      // A zero time scale: computes are refused, loads still land.
      configure(5'd1, 32'h0000_0000, 1'b0);
      queue_item(site_item(REQ_COMPUTE, 0, 0, 0, 0, 0, 0));
      queue_item(site_item(REQ_LOAD, 0, 0, 0, 32'h0000_0200, 0, 0));
      add_random(30);

      // A grid size past the lattice edge is held at the edge.
      configure(5'd31, 32'h0000_0001, 1'b0);
      add_random(50);

      configure(5'd2, $urandom, 1'b1);
      add_random(50);

      // A bad site is reported before a bad time scale.
      configure(5'd4, 32'h0000_0000, 1'b0);
      queue_item(site_item(REQ_COMPUTE, 5, 0, 0, 0, 0, 0));
      queue_item(site_item(REQ_COMPUTE, 1, 1, 1, 0, 0, 0));
      queue_item(site_item(REQ_COMPUTE, 0, 0, 4, 0, 0, 0));
      add_random(30);

      configure(GRID_W'($urandom_range(3, 15)), $urandom_range(1, 32'h0004_0000), 1'b0);
      add_random(100);

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/lef_pkg.sv
rtl/core/lef_queue.sv
rtl/core/lef_front.sv
rtl/core/lef_back.sv
rtl/core/lattice_electric_field_core.sv
verif/testbench.sv
